[rtl/risc_instruction_execute_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the execute unit
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef RISC_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH
`define RISC_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH

// same-cycle implication
`define RIEU_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RIEU_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/rieu_pkg.sv]
// ----------------------------------------------------------------------------
// rieu_pkg
// Widths, opcodes and shared types of the instruction execute unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rieu_pkg;

  localparam int unsigned MemWordsDef  = 2048;
  localparam int unsigned ProgWordsDef = 1024;

  localparam int unsigned XLen    = 32;
  localparam int unsigned RegIdxW = 5;
  localparam int unsigned NumRegs = 32;
  localparam int unsigned OpW     = 4;

  localparam logic [OpW-1:0] OpAdd  = 4'd0;
  localparam logic [OpW-1:0] OpSub  = 4'd1;
  localparam logic [OpW-1:0] OpMuli = 4'd2;
  localparam logic [OpW-1:0] OpAddi = 4'd3;
  localparam logic [OpW-1:0] OpBne  = 4'd4;
  localparam logic [OpW-1:0] OpAndi = 4'd5;
  localparam logic [OpW-1:0] OpOri  = 4'd6;
  localparam logic [OpW-1:0] OpJ    = 4'd7;
  localparam logic [OpW-1:0] OpSll  = 4'd8;
  localparam logic [OpW-1:0] OpSrl  = 4'd9;
  localparam logic [OpW-1:0] OpLw   = 4'd10;
  localparam logic [OpW-1:0] OpSw   = 4'd11;

  // register write / forward beat
  typedef struct packed {
    logic               en;
    logic [RegIdxW-1:0] idx;
    logic [XLen-1:0]    val;
  } rieu_fwd_t;

  // decoded control of one instruction
  typedef struct packed {
    logic wr;     // register write, destination nonzero
    logic ld;
    logic st;
    logic mul;
    logic redir;
  } rieu_ctl_t;

endpackage

[rtl/risc_instruction_execute_unit.sv]
// ----------------------------------------------------------------------------
// risc_instruction_execute_unit
// Executes one instruction per beat against a register file and data memory.
//
//   channel | direction | handshake              | payload
//   in      | sink      | in_valid_i/in_ready_o  | instruction_word, _address
//   out     | source    | out_valid_o/out_ready_i| reg_*, mem_*, pc_redirect...
//
// Throughput one instruction per cycle unless out_ready_i stalls the output;
// stages: register read, execute + data memory access, output register.
// After reset the data memory is cleared word by word, in_ready_o low.
// Stalls propagate stage by stage; an empty stage always accepts.
// MemWords and ProgWords must be powers of two.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module risc_instruction_execute_unit #(
  parameter int unsigned MemWords  = rieu_pkg::MemWordsDef,
  parameter int unsigned ProgWords = rieu_pkg::ProgWordsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [rieu_pkg::XLen-1:0]      instruction_word_i,
  input  logic [$clog2(ProgWords)-1:0]   instruction_address_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           reg_write_o,
  output logic [rieu_pkg::RegIdxW-1:0]   reg_index_o,
  output logic signed [rieu_pkg::XLen-1:0] reg_value_o,
  output logic                           mem_write_o,
  output logic [$clog2(MemWords)-1:0]    mem_address_o,
  output logic signed [rieu_pkg::XLen-1:0] mem_value_o,
  output logic                           pc_redirect_o,
  output logic [$clog2(ProgWords)-1:0]   next_pc_o
);
  import rieu_pkg::*;

  localparam int unsigned MemAddrW = $clog2(MemWords);
  localparam int unsigned PcW      = $clog2(ProgWords);

  // handshake
  logic out_adv, s2_adv, s1_adv, in_acc;

  // stage 1
  logic            s1_valid_q;
  logic [XLen-1:0] s1_iw_q;
  logic [PcW-1:0]  s1_pc_q;
  logic [XLen-1:0] rf_a, rf_b, rf_c;
  rieu_ctl_t       ex_ctl;
  logic [XLen-1:0] ex_val, ex_prod;
  logic [MemAddrW-1:0] ex_ea;
  logic [PcW-1:0]  ex_npc;

  // stage 2
  logic                s2_valid_q;
  rieu_ctl_t           s2_ctl_q;
  logic [RegIdxW-1:0]  s2_idx_q;
  logic [XLen-1:0]     s2_val_q, s2_prod_q, s2_sdata_q;
  logic [MemAddrW-1:0] s2_ea_q;
  logic [PcW-1:0]      s2_npc_q;
  logic [XLen-1:0]     dm_rdata, s2_rval;
  rieu_fwd_t           s2_fwd, rf_wr;

  // data memory port
  logic                dm_we, dm_re;
  logic [MemAddrW-1:0] dm_waddr;
  logic [XLen-1:0]     dm_wdata;

  // clearing pass
  logic                clr_busy_q;
  logic [MemAddrW-1:0] clr_cnt_q;

  // output register
  logic                out_valid_q;
  logic                out_rw_q, out_mw_q, out_redir_q;
  logic [RegIdxW-1:0]  out_idx_q;
  logic [XLen-1:0]     out_rval_q, out_mval_q;
  logic [MemAddrW-1:0] out_maddr_q;
  logic [PcW-1:0]      out_npc_q;

  assign out_adv    = !out_valid_q || out_ready_i;
  assign s2_adv     = !s2_valid_q || out_adv;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_ready_o = s1_adv && !clr_busy_q;
  assign in_acc     = in_valid_i && in_ready_o;

  rieu_regfile u_regfile (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .re_i     (s1_adv),
    .raddr_a_i(instruction_word_i[27:23]),
    .raddr_b_i(instruction_word_i[22:18]),
    .raddr_c_i(instruction_word_i[17:13]),
    .wr_i     (rf_wr),
    .fwd_i    (s2_fwd),
    .rdata_a_o(rf_a),
    .rdata_b_o(rf_b),
    .rdata_c_o(rf_c)
  );

  rieu_exec #(
    .MemAddrW(MemAddrW),
    .PcW     (PcW)
  ) u_exec (
    .iw_i  (s1_iw_q),
    .pc_i  (s1_pc_q),
    .a_i   (rf_a),
    .b_i   (rf_b),
    .c_i   (rf_c),
    .ctl_o (ex_ctl),
    .val_o (ex_val),
    .prod_o(ex_prod),
    .ea_o  (ex_ea),
    .npc_o (ex_npc)
  );

  assign dm_we    = clr_busy_q || (s1_valid_q && s2_adv && ex_ctl.st);
  assign dm_waddr = clr_busy_q ? clr_cnt_q : ex_ea;
  assign dm_wdata = clr_busy_q ? '0 : rf_a;
  assign dm_re    = s1_valid_q && s2_adv;

  rieu_ram #(
    .Width(XLen),
    .Depth(MemWords)
  ) u_dmem (
    .clk_i  (clk_i),
    .we_i   (dm_we),
    .waddr_i(dm_waddr),
    .wdata_i(dm_wdata),
    .re_i   (dm_re),
    .raddr_i(ex_ea),
    .rdata_o(dm_rdata)
  );

  always_comb begin
    if (s2_ctl_q.ld) begin
      s2_rval = dm_rdata;
    end else if (s2_ctl_q.mul) begin
      s2_rval = s2_prod_q;
    end else begin
      s2_rval = s2_val_q;
    end
  end

  assign s2_fwd.en  = s2_valid_q && s2_ctl_q.wr;
  assign s2_fwd.idx = s2_idx_q;
  assign s2_fwd.val = s2_rval;

  assign rf_wr.en  = s2_fwd.en && out_adv;
  assign rf_wr.idx = s2_idx_q;
  assign rf_wr.val = s2_rval;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s2_ctl_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + MemAddrW'(1);
        if (clr_cnt_q == MemAddrW'(MemWords - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (s1_adv) begin
        s1_valid_q <= in_acc;
      end
      if (s2_adv) begin
        s2_valid_q <= s1_valid_q;
        if (s1_valid_q) begin
          s2_ctl_q <= ex_ctl;
        end
      end
      if (out_adv) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_iw_q <= instruction_word_i;
      s1_pc_q <= instruction_address_i;
    end
    if (s2_adv && s1_valid_q) begin
      s2_idx_q   <= s1_iw_q[27:23];
      s2_val_q   <= ex_val;
      s2_prod_q  <= ex_prod;
      s2_sdata_q <= rf_a;
      s2_ea_q    <= ex_ea;
      s2_npc_q   <= ex_npc;
    end
    if (out_adv && s2_valid_q) begin
      out_rw_q    <= s2_ctl_q.wr;
      out_idx_q   <= s2_ctl_q.wr ? s2_idx_q : '0;
      out_rval_q  <= s2_ctl_q.wr ? s2_rval : '0;
      out_mw_q    <= s2_ctl_q.st;
      out_maddr_q <= s2_ea_q;
      out_mval_q  <= s2_ctl_q.ld ? dm_rdata : (s2_ctl_q.st ? s2_sdata_q : '0);
      out_redir_q <= s2_ctl_q.redir;
      out_npc_q   <= s2_npc_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign reg_write_o   = out_rw_q;
  assign reg_index_o   = out_idx_q;
  assign reg_value_o   = out_rval_q;
  assign mem_write_o   = out_mw_q;
  assign mem_address_o = out_maddr_q;
  assign mem_value_o   = out_mval_q;
  assign pc_redirect_o = out_redir_q;
  assign next_pc_o     = out_npc_q;

endmodule

[rtl/rieu_ram.sv]
// ----------------------------------------------------------------------------
// rieu_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rieu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rieu_regfile.sv]
// ----------------------------------------------------------------------------
// rieu_regfile
// Three-read register file on replicated RAMs, per-entry valid bits for the
// reset value, and bypass from the result stage and the last write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rieu_regfile (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                re_i,
  input  logic [rieu_pkg::RegIdxW-1:0]        raddr_a_i,
  input  logic [rieu_pkg::RegIdxW-1:0]        raddr_b_i,
  input  logic [rieu_pkg::RegIdxW-1:0]        raddr_c_i,
  input  rieu_pkg::rieu_fwd_t                 wr_i,
  input  rieu_pkg::rieu_fwd_t                 fwd_i,
  output logic [rieu_pkg::XLen-1:0]           rdata_a_o,
  output logic [rieu_pkg::XLen-1:0]           rdata_b_o,
  output logic [rieu_pkg::XLen-1:0]           rdata_c_o
);
  import rieu_pkg::*;

  localparam int unsigned NumPorts = 3;

  logic [NumRegs-1:0]                 valid_q, valid_d;
  logic [NumPorts-1:0][RegIdxW-1:0]   raddr;
  logic [NumPorts-1:0][RegIdxW-1:0]   ridx_q;
  logic [NumPorts-1:0]                rv_q;
  logic [NumPorts-1:0][XLen-1:0]      ram_rdata;
  logic [NumPorts-1:0][XLen-1:0]      rdata;
  rieu_fwd_t                          last_q;

  assign raddr[0] = raddr_a_i;
  assign raddr[1] = raddr_b_i;
  assign raddr[2] = raddr_c_i;

  for (genvar p = 0; p < NumPorts; p++) begin : g_port
    rieu_ram #(
      .Width(XLen),
      .Depth(NumRegs)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (wr_i.en),
      .waddr_i(wr_i.idx),
      .wdata_i(wr_i.val),
      .re_i   (re_i),
      .raddr_i(raddr[p]),
      .rdata_o(ram_rdata[p])
    );

    always_comb begin
      if (ridx_q[p] == '0) begin
        rdata[p] = '0;
      end else if (fwd_i.en && (fwd_i.idx == ridx_q[p])) begin
        rdata[p] = fwd_i.val;
      end else if (last_q.en && (last_q.idx == ridx_q[p])) begin
        rdata[p] = last_q.val;
      end else if (rv_q[p]) begin
        rdata[p] = ram_rdata[p];
      end else begin
        rdata[p] = '0;
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (wr_i.en) begin
      valid_d[wr_i.idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      last_q  <= '0;
      rv_q    <= '0;
      ridx_q  <= '0;
    end else begin
      valid_q <= valid_d;
      if (wr_i.en) begin
        last_q <= wr_i;
      end
      if (re_i) begin
        ridx_q <= raddr;
        for (int p = 0; p < NumPorts; p++) begin
          rv_q[p] <= valid_q[raddr[p]];
        end
      end
    end
  end

  assign rdata_a_o = rdata[0];
  assign rdata_b_o = rdata[1];
  assign rdata_c_o = rdata[2];

endmodule

[rtl/rieu_exec.sv]
// ----------------------------------------------------------------------------
// rieu_exec
// Decode and execute: ALU, multiplier, effective address, branch target.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rieu_exec #(
  parameter int unsigned MemAddrW = 11,
  parameter int unsigned PcW      = 10
) (
  input  logic [rieu_pkg::XLen-1:0] iw_i,
  input  logic [PcW-1:0]            pc_i,
  input  logic [rieu_pkg::XLen-1:0] a_i,
  input  logic [rieu_pkg::XLen-1:0] b_i,
  input  logic [rieu_pkg::XLen-1:0] c_i,
  output rieu_pkg::rieu_ctl_t       ctl_o,
  output logic [rieu_pkg::XLen-1:0] val_o,
  output logic [rieu_pkg::XLen-1:0] prod_o,
  output logic [MemAddrW-1:0]       ea_o,
  output logic [PcW-1:0]            npc_o
);
  import rieu_pkg::*;

  logic [OpW-1:0]     op;
  logic [RegIdxW-1:0] r1;
  logic [XLen-1:0]    imm;
  logic [12:0]        shamt;
  logic [XLen-1:0]    sum_ea;
  logic [XLen-1:0]    br_tgt;
  logic               wr;

  assign op     = iw_i[31:28];
  assign r1     = iw_i[27:23];
  assign imm    = {{14{iw_i[17]}}, iw_i[17:0]};
  assign shamt  = iw_i[12:0];
  assign sum_ea = b_i + imm;
  assign br_tgt = XLen'(pc_i) + XLen'(1) + imm;
  assign prod_o = b_i * imm;

  always_comb begin
    wr        = 1'b0;
    ctl_o     = '0;
    val_o     = '0;
    ea_o      = '0;
    npc_o     = '0;
    case (op)
      OpAdd: begin
        wr    = 1'b1;
        val_o = b_i + c_i;
      end
      OpSub: begin
        wr    = 1'b1;
        val_o = b_i - c_i;
      end
      OpMuli: begin
        wr        = 1'b1;
        ctl_o.mul = 1'b1;
      end
      OpAddi: begin
        wr    = 1'b1;
        val_o = sum_ea;
      end
      OpBne: begin
        if (b_i != a_i) begin
          ctl_o.redir = 1'b1;
          npc_o       = br_tgt[PcW-1:0];
        end
      end
      OpAndi: begin
        wr    = 1'b1;
        val_o = b_i & imm;
      end
      OpOri: begin
        wr    = 1'b1;
        val_o = b_i | imm;
      end
      OpJ: begin
        ctl_o.redir = 1'b1;
        npc_o       = iw_i[PcW-1:0];
      end
      OpSll: begin
        wr    = 1'b1;
        val_o = (shamt[12:5] == '0) ? (b_i << shamt[4:0]) : '0;
      end
      OpSrl: begin
        wr    = 1'b1;
        val_o = (shamt[12:5] == '0) ? (b_i >> shamt[4:0]) : '0;
      end
      OpLw: begin
        wr       = 1'b1;
        ctl_o.ld = 1'b1;
        ea_o     = sum_ea[MemAddrW-1:0];
      end
      OpSw: begin
        ctl_o.st = 1'b1;
        ea_o     = sum_ea[MemAddrW-1:0];
      end
      default: begin
        wr = 1'b0;
      end
    endcase
    ctl_o.wr = wr && (r1 != '0);
  end

endmodule

[rtl/rieu_checker.sv]
// ----------------------------------------------------------------------------
// rieu_checker
// Port-level checks on result beats of the execute unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "risc_instruction_execute_unit_macros.svh"

module rieu_checker #(
  parameter int unsigned MemWords  = rieu_pkg::MemWordsDef,
  parameter int unsigned ProgWords = rieu_pkg::ProgWordsDef
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic                             reg_write_o,
  input logic [rieu_pkg::RegIdxW-1:0]     reg_index_o,
  input logic signed [rieu_pkg::XLen-1:0] reg_value_o,
  input logic                             mem_write_o,
  input logic [$clog2(MemWords)-1:0]      mem_address_o,
  input logic signed [rieu_pkg::XLen-1:0] mem_value_o,
  input logic                             pc_redirect_o,
  input logic [$clog2(ProgWords)-1:0]     next_pc_o
);

  `RIEU_ASSERT_IMP(a_no_reg_fields, clk_i, rst_ni, out_valid_o && !reg_write_o,
    (reg_index_o == '0) && (reg_value_o == '0), "register fields set without write")

  `RIEU_ASSERT_IMP(a_no_r0_write, clk_i, rst_ni, out_valid_o && reg_write_o,
    reg_index_o != '0, "write reported to register zero")

  `RIEU_ASSERT_IMP(a_store_alone, clk_i, rst_ni, out_valid_o && mem_write_o,
    !reg_write_o && !pc_redirect_o, "store beat carries other effects")

  `RIEU_ASSERT_IMP(a_no_pc_field, clk_i, rst_ni, out_valid_o && !pc_redirect_o,
    next_pc_o == '0, "next pc set without redirect")

  `RIEU_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable({reg_write_o, reg_index_o, reg_value_o, mem_write_o, mem_address_o, mem_value_o, pc_redirect_o, next_pc_o}), "result beat dropped")

endmodule

bind risc_instruction_execute_unit rieu_checker #(
  .MemWords (MemWords),
  .ProgWords(ProgWords)
) u_rieu_checker (.*);
